### hw/rtl/utf8s_pkg.sv
// Shared types, constants and lead-byte decode for the UTF-8 sanitizer.
`default_nettype none

package utf8s_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned HoldN  = 3;
  localparam int unsigned LitN   = 4;

  typedef logic [ByteW-1:0] byte_t;

  // U+FFFD replacement character
  localparam byte_t ReplByte0 = 8'hEF;
  localparam byte_t ReplByte1 = 8'hBF;
  localparam byte_t ReplByte2 = 8'hBD;

  localparam logic [2:0] LenInvalid = 3'd0;
  localparam logic [2:0] LenAscii   = 3'd1;
  localparam logic [2:0] LenTwo     = 3'd2;
  localparam logic [2:0] LenThree   = 3'd3;
  localparam logic [2:0] LenFour    = 3'd4;

  localparam logic [1:0] ContTag    = 2'b10;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic repl_adv;
    logic lit_adv;
    logic sel_lit;
  } utf8s_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic new_repl;
    logic new_lit;
    logic repl_final;
    logic lit_final;
    logic has_lit;
    logic job_last;
  } utf8s_status_t;

  function automatic logic [2:0] lead_len(input byte_t b);
    logic [2:0] len;
    if (!b[7]) begin
      len = LenAscii;
    end else if (b[7:5] == 3'b110) begin
      len = LenTwo;
    end else if (b[7:4] == 4'b1110) begin
      len = LenThree;
    end else if (b[7:3] == 5'b11110) begin
      len = LenFour;
    end else begin
      len = LenInvalid;
    end
    return len;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/utf8s_if.sv
// Valid/ready stream interfaces for the sanitizer input and output channels.
`default_nettype none

interface utf8s_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last_byte;

  modport source (output valid, output in_byte, output last_byte, input ready);
  modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

interface utf8s_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  logic       string_end;

  modport source (output valid, output out_byte, output run_end, output string_end,
                  input ready);
  modport sink   (input valid, input out_byte, input run_end, input string_end,
                  output ready);
endinterface

`default_nettype wire

### hw/rtl/utf8s_ctrl.sv
// Sanitizer controller: accepts a byte, then sequences replacement and literal output.
`default_nettype none

module utf8s_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    out_ready_i,
  input  utf8s_pkg::utf8s_status_t status_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  output logic                    run_end_o,
  output logic                    string_end_o,
  output utf8s_pkg::utf8s_cmd_t    cmd_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRepl = 2'd1;
  localparam logic [1:0] StLit  = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    run_end_o   = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (status_i.new_repl) begin
            state_d = StRepl;
          end else if (status_i.new_lit) begin
            state_d = StLit;
          end
        end
      end
      StRepl: begin
        out_valid_o = 1'b1;
        run_end_o   = status_i.repl_final & ~status_i.has_lit;
        if (out_ready_i) begin
          cmd_o.repl_adv = 1'b1;
          if (status_i.repl_final) begin
            state_d = status_i.has_lit ? StLit : StIdle;
          end
        end
      end
      StLit: begin
        out_valid_o   = 1'b1;
        cmd_o.sel_lit = 1'b1;
        run_end_o     = status_i.lit_final;
        if (out_ready_i) begin
          cmd_o.lit_adv = 1'b1;
          if (status_i.lit_final) begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  assign string_end_o = run_end_o & status_i.job_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/utf8s_dp.sv
// Sanitizer datapath: held-sequence state, per-transaction job registers, output mux.
`default_nettype none

module utf8s_dp (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  utf8s_pkg::utf8s_cmd_t     cmd_i,
  input  utf8s_pkg::byte_t          in_byte_i,
  input  logic                     last_byte_i,
  output utf8s_pkg::utf8s_status_t  status_o,
  output utf8s_pkg::byte_t          out_byte_o
);

  localparam logic [1:0] TriLast = 2'd2;

  // held sequence
  utf8s_pkg::byte_t pend_q [utf8s_pkg::HoldN];
  logic [1:0]       cnt_q, cnt_d;
  logic [2:0]       explen_q, explen_d;

  // current job
  utf8s_pkg::byte_t lit_buf_q [utf8s_pkg::LitN];
  utf8s_pkg::byte_t lit_buf_d [utf8s_pkg::LitN];
  logic [2:0]       lit_n_q, lit_n_d;
  logic [1:0]       lit_idx_q;
  logic [2:0]       repl_left_q, repl_n;
  logic [1:0]       tri_idx_q;
  logic             job_last_q;

  logic       holding, is_cont, complete, store, broken, take_lead, hold_lead;
  logic [2:0] len;
  logic [1:0] lit_from_pend;

  always_comb begin
    holding   = (cnt_q != 2'd0);
    is_cont   = (in_byte_i[7:6] == utf8s_pkg::ContTag);
    len       = utf8s_pkg::lead_len(in_byte_i);
    complete  = holding & is_cont & (({1'b0, cnt_q} + 3'd1) >= explen_q);
    store     = holding & is_cont & ~complete;
    broken    = holding & ~is_cont;
    take_lead = ~holding | broken;
    hold_lead = take_lead & (len >= utf8s_pkg::LenTwo);

    repl_n = '0;
    if (broken) begin
      repl_n = {1'b0, cnt_q};
    end
    if (store && last_byte_i) begin
      repl_n = {1'b0, cnt_q} + 3'd1;
    end
    if (take_lead && len == utf8s_pkg::LenInvalid) begin
      repl_n = repl_n + 3'd1;
    end
    if (hold_lead && last_byte_i) begin
      repl_n = repl_n + 3'd1;
    end

    lit_n_d = '0;
    if (complete) begin
      lit_n_d = {1'b0, cnt_q} + 3'd1;
    end else if (take_lead && len == utf8s_pkg::LenAscii) begin
      lit_n_d = 3'd1;
    end

    lit_from_pend = complete ? cnt_q : 2'd0;
    for (int i = 0; i < utf8s_pkg::HoldN; i++) begin
      lit_buf_d[i] = (2'(i) < lit_from_pend) ? pend_q[i] : in_byte_i;
    end
    lit_buf_d[utf8s_pkg::LitN-1] = in_byte_i;

    cnt_d    = cnt_q;
    explen_d = explen_q;
    if (complete) begin
      cnt_d    = 2'd0;
      explen_d = 3'd0;
    end else if (store) begin
      cnt_d = cnt_q + 2'd1;
    end else if (hold_lead) begin
      cnt_d    = 2'd1;
      explen_d = len;
    end else begin
      cnt_d    = 2'd0;
      explen_d = 3'd0;
    end
    if (last_byte_i) begin
      cnt_d    = 2'd0;
      explen_d = 3'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < utf8s_pkg::HoldN; i++) begin
        if (store && cnt_q == 2'(i)) begin
          pend_q[i] <= in_byte_i;
        end
      end
      if (hold_lead) begin
        pend_q[0] <= in_byte_i;
      end
      for (int i = 0; i < utf8s_pkg::LitN; i++) begin
        lit_buf_q[i] <= lit_buf_d[i];
      end
      job_last_q <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      explen_q    <= '0;
      lit_n_q     <= '0;
      lit_idx_q   <= '0;
      repl_left_q <= '0;
      tri_idx_q   <= '0;
    end else if (cmd_i.load) begin
      cnt_q       <= cnt_d;
      explen_q    <= explen_d;
      lit_n_q     <= lit_n_d;
      lit_idx_q   <= '0;
      repl_left_q <= repl_n;
      tri_idx_q   <= '0;
    end else begin
      if (cmd_i.repl_adv) begin
        if (tri_idx_q == TriLast) begin
          tri_idx_q   <= '0;
          repl_left_q <= repl_left_q - 3'd1;
        end else begin
          tri_idx_q <= tri_idx_q + 2'd1;
        end
      end
      if (cmd_i.lit_adv) begin
        lit_idx_q <= lit_idx_q + 2'd1;
      end
    end
  end

  always_comb begin
    status_o.new_repl   = (repl_n != 3'd0);
    status_o.new_lit    = (lit_n_d != 3'd0);
    status_o.repl_final = (tri_idx_q == TriLast) && (repl_left_q == 3'd1);
    status_o.lit_final  = ({1'b0, lit_idx_q} == (lit_n_q - 3'd1));
    status_o.has_lit    = (lit_n_q != 3'd0);
    status_o.job_last   = job_last_q;
  end

  always_comb begin
    if (cmd_i.sel_lit) begin
      out_byte_o = lit_buf_q[lit_idx_q];
    end else begin
      case (tri_idx_q)
        2'd0:    out_byte_o = utf8s_pkg::ReplByte0;
        2'd1:    out_byte_o = utf8s_pkg::ReplByte1;
        default: out_byte_o = utf8s_pkg::ReplByte2;
      endcase
    end
  end

  // held state consistency
  a_empty_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == 2'd0) |-> (explen_q == 3'd0))
    else $error("expected length set with nothing held");

  a_held_below_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != 2'd0) |-> (explen_q > {1'b0, cnt_q}) && (explen_q <= utf8s_pkg::LenFour))
    else $error("held count not below sequence length");

  a_repl_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (repl_left_q <= 3'd4) && (lit_n_q <= 3'd4))
    else $error("job counts out of range");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.load && last_byte_i) |=> (cnt_q == 2'd0))
    else $error("held bytes remain after end of string");

endmodule

`default_nettype wire

### hw/rtl/utf8_sanitizer_top.sv
// UTF-8 sanitizer top level: controller plus datapath on two stream channels.
//
// Usage:
//   in_i  carries one raw byte per transaction (in_byte) with last_byte set on the
//         final byte of a string. out_o carries the sanitized byte stream;
//         run_end marks the last output byte caused by an input byte and
//         string_end the last output byte of a string.
//   A complete 10xxxxxx-continued sequence passes through unchanged; every
//   byte that cannot start or finish a sequence becomes EF BF BD.
// Timing:
//   An input byte is taken in the idle state; its output bytes follow one per
//   cycle while out ready is high, starting the next cycle. No new input byte is
//   taken until they are all sent; a byte that is only held leaves the block idle.
//   Output is sequenced by the single output byte sequencer in the controller.
// Reset:
//   rst_ni clears the held-sequence count and the controller to idle.
// Stall:
//   While out ready is low the current output byte and its flags hold, and no
//   new input byte is accepted.
`default_nettype none

module utf8_sanitizer_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  utf8s_in_if.sink      in_i,
  utf8s_out_if.source   out_o
);

  utf8s_pkg::utf8s_cmd_t    cmd;
  utf8s_pkg::utf8s_status_t status;
  utf8s_pkg::byte_t         out_byte;
  logic                     in_ready;
  logic                     out_valid;
  logic                     run_end;
  logic                     string_end;

  utf8s_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .out_ready_i  (out_o.ready),
    .status_i     (status),
    .in_ready_o   (in_ready),
    .out_valid_o  (out_valid),
    .run_end_o    (run_end),
    .string_end_o (string_end),
    .cmd_o        (cmd)
  );

  utf8s_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_byte_i   (in_i.in_byte),
    .last_byte_i (in_i.last_byte),
    .status_o    (status),
    .out_byte_o  (out_byte)
  );

  assign in_i.ready       = in_ready;
  assign out_o.valid      = out_valid;
  assign out_o.out_byte   = out_byte;
  assign out_o.run_end    = run_end;
  assign out_o.string_end = string_end;

endmodule

`default_nettype wire
